// ----- src/bae_pkg.sv -----
package bae_pkg;

    localparam int unsigned PUSH_SHIFT = 32;

    localparam logic [63:0] LOW_RESET  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] HIGH_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] PUSH_MASK  = 32'hFFFF_FFFF;

    localparam logic [2:0] LAST_LONG  = 3'd7;
    localparam logic [2:0] LAST_SHORT = 3'd3;

    typedef struct packed {
        logic        func;
        logic        bit_value;
        logic [15:0] prob_zero;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic       is_flush;
        logic       bit_value;
        logic [7:0] odds;
    } t_cmd;

    typedef struct packed {
        logic [63:0] data;
        logic        long_run;
    } t_word;

endpackage

// ----- src/binary_arith_encoder_64bit.sv -----
// Channel   Handshake           Payload     Moves
// input     push / full         i_item      one request: encode a bit or flush
// result    empty / pop         o_result    one byte of the coded stream
//
// An encode request goes through the interval engine, which forms the
// split point with a 56x8 multiply and a 64-bit add; a renormalising one
// passes through ST_RUN, ST_ADJ, ST_EMIT (which waits on a full word queue),
// ST_RANGE and ST_CODE. A flush yields eight bytes. Synchronous active-low
// reset empties both queues and restores the full interval. A stalled
// result side fills the word queue, then the request queue, and full rises.
module binary_arith_encoder_64bit import bae_pkg::*; #(
    parameter int unsigned CMD_DEPTH  = 4,
    parameter int unsigned WORD_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    t_cmd  w_cmd;
    logic  w_cmd_empty;
    logic  w_cmd_pop;
    t_word w_word;
    logic  w_word_push;
    logic  w_word_full;

    bae_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    bae_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_word      (w_word),
        .o_word_push (w_word_push),
        .i_word_full (w_word_full)
    );

    bae_emit #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .i_word_push (w_word_push),
        .o_word_full (w_word_full),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

// ----- src/bae_fifo.sv -----
module bae_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/bae_front.sv -----
module bae_front import bae_pkg::*; #(
    parameter int unsigned CMD_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd,
    output logic     o_cmd_empty
);

    t_cmd w_cmd;

    // classify: keep only the fields that the interval engine needs
    always_comb begin
        w_cmd.is_flush  = i_item.func;
        w_cmd.bit_value = i_item.bit_value;
        w_cmd.odds      = i_item.prob_zero[15:8];
    end

    bae_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

// ----- src/bae_core.sv -----
module bae_core import bae_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_cmd_empty,
    output logic  o_cmd_pop,
    output t_word o_word,
    output logic  o_word_push,
    input  logic  i_word_full
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_ADJ,
        ST_EMIT,
        ST_RANGE,
        ST_CODE
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_low, n_low;
    logic [63:0] r_high, n_high;
    logic [63:0] r_range, n_range;
    logic [63:0] r_dl, n_dl;
    logic [63:0] r_dh, n_dh;
    logic        r_differ, n_differ;

    logic [63:0] w_prod;
    logic [63:0] w_mid;
    logic        w_narrow;

    assign w_prod   = {8'd0, r_range[63:8]} * {56'd0, i_cmd.odds};
    assign w_mid    = r_low + w_prod;
    assign w_narrow = (r_range[63:16] == '0);

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_range     = r_range;
        n_dl        = r_dl;
        n_dh        = r_dh;
        n_differ    = r_differ;
        o_cmd_pop   = 1'b0;
        o_word_push = 1'b0;
        o_word      = '{data: r_low + {1'b0, r_range[63:1]}, long_run: 1'b1};

        case (r_state)
            ST_RUN: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.is_flush) begin
                        if (!i_word_full) begin
                            o_word_push = 1'b1;
                            o_cmd_pop   = 1'b1;
                            n_low       = LOW_RESET;
                            n_high      = HIGH_RESET;
                            n_range     = HIGH_RESET - LOW_RESET;
                        end
                    end else if (w_narrow) begin
                        n_dl     = {r_high[63:32], 32'd0} - r_low;
                        n_dh     = r_high - {r_low[63:32], PUSH_MASK};
                        n_differ = (r_low[63:32] != r_high[63:32]);
                        n_state  = ST_ADJ;
                    end else begin
                        o_cmd_pop = 1'b1;
                        if (i_cmd.bit_value) begin
                            n_low   = w_mid;
                            n_range = r_range - w_prod;
                        end else begin
                            n_high  = w_mid;
                            n_range = w_prod;
                        end
                    end
                end
            end
            ST_ADJ: begin
                if (r_differ) begin
                    if (r_dl < r_dh) begin
                        n_low = {r_high[63:32], 32'd0};
                    end else begin
                        n_high = {r_low[63:32], PUSH_MASK};
                    end
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_word = '{data: {r_low[63:32], 32'd0}, long_run: 1'b0};
                if (!i_word_full) begin
                    o_word_push = 1'b1;
                    n_low       = r_low << PUSH_SHIFT;
                    n_high      = r_high << PUSH_SHIFT;
                    n_state     = ST_RANGE;
                end
            end
            ST_RANGE: begin
                n_range = r_high - r_low;
                n_state = ST_CODE;
            end
            ST_CODE: begin
                o_cmd_pop = 1'b1;
                if (i_cmd.bit_value) begin
                    n_low   = w_mid;
                    n_range = r_range - w_prod;
                end else begin
                    n_high  = w_mid;
                    n_range = w_prod;
                end
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_low    <= LOW_RESET;
            r_high   <= HIGH_RESET;
            r_range  <= HIGH_RESET - LOW_RESET;
            r_differ <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_high   <= n_high;
            r_range  <= n_range;
            r_differ <= n_differ;
        end
        r_dl <= n_dl;
        r_dh <= n_dh;
    end

endmodule

// ----- src/bae_emit.sv -----
module bae_emit import bae_pkg::*; #(
    parameter int unsigned WORD_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_word     i_word,
    input  logic      i_word_push,
    output logic      o_word_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    t_word       w_head;
    logic        w_q_empty;
    logic        w_load;
    logic [63:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;

    bae_fifo #(
        .WIDTH ($bits(t_word)),
        .DEPTH (WORD_DEPTH)
    ) u_word_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_word_push),
        .i_data  (i_word),
        .o_full  (o_word_full),
        .i_pop   (w_load),
        .o_data  (w_head),
        .o_empty (w_q_empty)
    );

    assign o_empty              = !r_busy;
    assign o_result.out_byte    = r_word[63:56];
    assign o_result.last_of_run = (r_cnt == '0);
    assign w_load = !w_q_empty && (!r_busy || (i_pop && r_cnt == '0));

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (w_load) begin
            n_word = w_head.data;
            n_cnt  = w_head.long_run ? LAST_LONG : LAST_SHORT;
            n_busy = 1'b1;
        end else if (i_pop && r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_word = r_word << 8;
                n_cnt  = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_word <= n_word;
    end

endmodule

// ----- src/bae_checker.sv -----
module bae_checker import bae_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    logic [2:0] r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (pop && !empty) begin
            r_run <= o_result.last_of_run ? 3'd0 : r_run + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.last_of_run |-> r_run == LAST_SHORT || r_run == LAST_LONG)
        else $error("run ends after wrong byte count");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.last_of_run |-> r_run != LAST_LONG)
        else $error("run longer than eight bytes");

endmodule

bind binary_arith_encoder_64bit bae_checker u_bae_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ----- verif/tb_binary_arith_encoder_64bit.sv -----
module tb_binary_arith_encoder_64bit;
    timeunit 1ns;
    timeprecision 1ps;

    import bae_pkg::*;

    localparam logic        OP_ENCODE = 1'b0;
    localparam logic        OP_FLUSH  = 1'b1;
    localparam logic [63:0] MIN_SPAN  = 64'h0000_0000_0001_0000;
    localparam int          FREE      = -1;

    typedef struct {
        t_in_item    req;
        int          pin_n;
        logic [63:0] pin_word;
    } t_plan_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    logic [63:0] code_low  = LOW_RESET;
    logic [63:0] code_high = HIGH_RESET;
    t_out_item   coded_bytes_q[$];
    t_plan_row   plan_q[$];

    int          pin_n = FREE;
    logic [63:0] pin_word = '0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_rx = 1'b0;
    int          hold_left = 0;
    int          err_cnt = 0;

    binary_arith_encoder_64bit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the interval by one request; n bytes of word leave, MSB first.
    function automatic void code_request(input t_in_item req, output int n,
                                         output logic [63:0] word);
        logic [63:0] span;
        logic [63:0] mid;
        logic [63:0] low_cap;
        logic [63:0] high_cut;
        logic [63:0] d_low;
        logic [63:0] d_high;
        n = 0;
        word = '0;
        span = code_high - code_low;
        if (req.func == OP_FLUSH) begin
            word = code_low + (span >> 1);
            n = 8;
            code_low = LOW_RESET;
            code_high = HIGH_RESET;
            return;
        end
        if (span < MIN_SPAN) begin
            if (code_low[63:32] != code_high[63:32]) begin
                low_cap = {code_low[63:32], PUSH_MASK};
                high_cut = {code_high[63:32], 32'h0};
                d_high = code_high - low_cap;
                d_low = high_cut - code_low;
                if (d_low < d_high) begin
                    code_low = high_cut;
                end else begin
                    code_high = low_cap;
                end
            end
            word = code_low;
            n = 4;
            code_low = code_low << PUSH_SHIFT;
            code_high = code_high << PUSH_SHIFT;
            span = code_high - code_low;
        end
        mid = code_low + (span >> 8) * req.prob_zero[15:8];
        if (req.bit_value) begin
            code_low = mid;
        end else begin
            code_high = mid;
        end
    endfunction

    function automatic t_in_item make_request(input bit flush_heavy);
        t_in_item req;
        int roll;
        req.func = OP_ENCODE;
        req.bit_value = 1'($urandom_range(1));
        req.prob_zero = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < (flush_heavy ? 60 : 4)) begin
            req.func = OP_FLUSH;
            return req;
        end
        roll = $urandom_range(99);
        if (roll < 45) begin
            // narrow the interval fast so renormalisation comes often
            req.prob_zero[15:8] = req.bit_value ? 8'($urandom_range(252, 255))
                                                : 8'($urandom_range(1, 3));
        end else if (roll < 55) begin
            case ($urandom_range(5))
                0: req.prob_zero = 16'h0000;
                1: req.prob_zero = 16'h00FF;
                2: req.prob_zero = 16'h0100;
                3: req.prob_zero = 16'hFF00;
                4: req.prob_zero = 16'hFFFF;
                default: req.prob_zero = 16'h8000;
            endcase
        end
        return req;
    endfunction

    task automatic add_row(input logic op, input logic bit_v, input logic [15:0] prob,
                           input int n, input logic [63:0] word);
        t_plan_row row;
        row.req.func = op;
        row.req.bit_value = bit_v;
        row.req.prob_zero = prob;
        row.pin_n = n;
        row.pin_word = word;
        plan_q.push_back(row);
    endtask

    task automatic send_request(input t_in_item req, input int n, input logic [63:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        pin_n = n;
        pin_word = word;
        push <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (coded_bytes_q.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : scoreboard
        int n;
        logic [63:0] word;
        t_out_item want;
        if (i_rst_n) begin
            if (push && !full) begin
                code_request(i_item, n, word);
                if (pin_n != FREE) begin
                    n = pin_n;
                    word = pin_word;
                end
                for (int k = 0; k < n; k++) begin
                    want.out_byte = word[63 - 8 * k -: 8];
                    want.last_of_run = (k == n - 1);
                    coded_bytes_q.push_back(want);
                end
            end
            if (pop && !empty) begin
                if (coded_bytes_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h last_of_run %0b",
                           o_result.out_byte, o_result.last_of_run);
                    err_cnt++;
                end else begin
                    want = coded_bytes_q.pop_front();
                    if (o_result.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, o_result.out_byte);
                        err_cnt++;
                    end
                    if (o_result.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, o_result.last_of_run);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("binary_arith_encoder_64bit test failed");
        $finish;
    end

    initial begin
        push = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;

        add_row(OP_FLUSH,  1'b0, 16'h0000, 8, 64'h7FFF_FFFF_FFFF_FFFF);
        add_row(OP_ENCODE, 1'b1, 16'h00FF, FREE, '0);
        add_row(OP_FLUSH,  1'b1, 16'hFFFF, 8, 64'h7FFF_FFFF_FFFF_FFFF);
        add_row(OP_ENCODE, 1'b0, 16'h0000, FREE, '0);
        add_row(OP_ENCODE, 1'b1, 16'hFFFF, 4, 64'h0);
        add_row(OP_FLUSH,  1'b0, 16'h1234, 8, 64'h0);
        add_row(OP_ENCODE, 1'b0, 16'hFFFF, FREE, '0);
        for (int k = 0; k < 8; k++) add_row(OP_ENCODE, 1'b0, 16'h0100, FREE, '0);
        add_row(OP_FLUSH,  1'b0, 16'h0000, FREE, '0);
        for (int k = 0; k < 8; k++) add_row(OP_ENCODE, 1'b1, 16'hFF00, FREE, '0);
        add_row(OP_FLUSH,  1'b1, 16'h00FF, FREE, '0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 11;
        rx_idle_pct = 79;
        foreach (plan_q[k]) send_request(plan_q[k].req, plan_q[k].pin_n, plan_q[k].pin_word);
        repeat (150) send_request(make_request(1'b0), FREE, '0);
        drain_results();

        tx_idle_pct = 79;
        rx_idle_pct = 11;
        repeat (150) send_request(make_request(1'b0), FREE, '0);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_rx = 1'b1;
        repeat (40) send_request(make_request(1'b1), FREE, '0);
        repeat (120) send_request(make_request(1'b0), FREE, '0);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("binary_arith_encoder_64bit test passed");
        end else begin
            $display("binary_arith_encoder_64bit test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/bae_pkg.sv
src/bae_fifo.sv
src/bae_front.sv
src/bae_core.sv
src/bae_emit.sv
src/binary_arith_encoder_64bit.sv
src/bae_checker.sv
verif/tb_binary_arith_encoder_64bit.sv
